/* rtl/core/ccd_pkg.sv */
package ccd_pkg;

	localparam int CostW     = 32;
	localparam int SumW      = 48;
	localparam int AddW      = CostW + 1;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 32;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [CostW-1:0] MultiplierReset = 32'h0001_0000;

	localparam logic CmdStart = 1'b0;
	localparam logic CmdEdge  = 1'b1;

	localparam logic [1:0] StAvailable = 2'd0;
	localparam logic [1:0] StReserve   = 2'd1;
	localparam logic [1:0] StLockedIn  = 2'd2;
	localparam logic [1:0] StLockedOut = 2'd3;

	localparam logic [CfgIdxW-1:0] RegCostMultiplier = 2'd0;
	localparam logic [CfgIdxW-1:0] RegAsymmetricMode = 2'd1;
	localparam logic [CfgIdxW-1:0] RegOptimiseInside = 2'd2;

	typedef struct packed {
		logic asymmetric;
		logic optimise_inside;
	} mode_t;

	typedef struct packed {
		logic                   load;
		logic                   last;
		logic signed [AddW-1:0] addend;
	} entry_t;

endpackage

/* rtl/core/connection_cost_delta_unit.sv */
// Connection cost delta unit.
// Input channel (item_valid / item_stall) takes one item per transfer: a start
// item (command low) loads the running sum with the signed fixed cost and
// latches the add/remove and annealing flags; neighbour items (command high)
// add, subtract or skip their edge cost per the configured rules.
// An item with last_item set produces one transfer on the result channel
// (result_valid / result_stall): running sum times cost_multiplier, shifted
// by FRAC_BITS, saturated to 48 bits, with saturated flagging any clip.
// Throughput: one item per cycle while item_stall is low; a 4-entry queue
// splits classification from the accumulator, which takes one add per cycle
// unless a last item waits on a stalled snapshot stage. After the queue, the
// result is registered in the snapshot, magnitude, two-partial-product, limit
// and sign stages. Config writes (cfg_write, cfg_index, cfg_data) are
// registered and are meant for idle periods only; index 3 is ignored.
// Reset clears the sum, flags, queue and pipeline; the multiplier resets to
// 1.0. When result_stall is high the pipeline backs up, then the queue fills,
// and item_stall rises once the queue is full; nothing is dropped.
module connection_cost_delta_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [ccd_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [ccd_pkg::CfgDataW-1:0]       cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               command,
	input  logic [ccd_pkg::CostW-1:0]          fixed_cost,
	input  logic                               removing_unit,
	input  logic                               from_annealing,
	input  logic [1:0]                         neighbour_status,
	input  logic                               edge_from_unit,
	input  logic [ccd_pkg::CostW-1:0]          edge_cost,
	input  logic                               last_item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [ccd_pkg::SumW-1:0]    cost_delta,
	output logic                               saturated
);

	logic [ccd_pkg::CostW-1:0] multiplier_q;
	logic                      asymmetric_q;
	logic                      optimise_inside_q;
	ccd_pkg::mode_t            mode;
	logic                      queue_full;
	logic                      push;
	ccd_pkg::entry_t           push_entry;
	logic                      pop;
	logic                      head_valid;
	ccd_pkg::entry_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiplier_q      <= ccd_pkg::MultiplierReset;
			asymmetric_q      <= 1'b0;
			optimise_inside_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ccd_pkg::RegCostMultiplier: multiplier_q      <= cfg_data;
				ccd_pkg::RegAsymmetricMode: asymmetric_q      <= cfg_data[0];
				ccd_pkg::RegOptimiseInside: optimise_inside_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign mode.asymmetric      = asymmetric_q;
	assign mode.optimise_inside = optimise_inside_q;

	ccd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.mode             (mode),
		.queue_full       (queue_full),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.command          (command),
		.fixed_cost       (fixed_cost),
		.removing_unit    (removing_unit),
		.from_annealing   (from_annealing),
		.neighbour_status (neighbour_status),
		.edge_from_unit   (edge_from_unit),
		.edge_cost        (edge_cost),
		.last_item        (last_item),
		.push             (push),
		.push_entry       (push_entry)
	);

	ccd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (queue_full)
	);

	ccd_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.multiplier   (multiplier_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cost_delta   (cost_delta),
		.saturated    (saturated)
	);

endmodule

/* rtl/core/ccd_front.sv */
module ccd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ccd_pkg::mode_t            mode,
	input  logic                      queue_full,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      command,
	input  logic [ccd_pkg::CostW-1:0] fixed_cost,
	input  logic                      removing_unit,
	input  logic                      from_annealing,
	input  logic [1:0]                neighbour_status,
	input  logic                      edge_from_unit,
	input  logic [ccd_pkg::CostW-1:0] edge_cost,
	input  logic                      last_item,
	output logic                      push,
	output ccd_pkg::entry_t           push_entry
);

	logic removing_q;
	logic annealing_q;
	logic in_reserve;
	logic signed [ccd_pkg::AddW-1:0] cost;
	logic signed [ccd_pkg::AddW-1:0] signed_cost;
	logic signed [ccd_pkg::AddW-1:0] other;
	logic signed [ccd_pkg::AddW-1:0] fixed;
	logic signed [ccd_pkg::AddW-1:0] edge_addend;

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	always_comb begin
		cost        = $signed({1'b0, edge_cost});
		fixed       = $signed({1'b0, fixed_cost});
		in_reserve  = (neighbour_status == ccd_pkg::StReserve) ||
		              (neighbour_status == ccd_pkg::StLockedIn);
		signed_cost = removing_q ? -cost : cost;
		other       = annealing_q ? -signed_cost : '0;
		edge_addend = '0;
		if (mode.asymmetric) begin
			if (annealing_q) begin
				if (edge_from_unit) begin
					if (neighbour_status == ccd_pkg::StAvailable)
						edge_addend = signed_cost;
				end else if (in_reserve) begin
					edge_addend = -signed_cost;
				end
			end else if (edge_from_unit && neighbour_status == ccd_pkg::StAvailable) begin
				edge_addend = cost;
			end
		end else if (mode.optimise_inside) begin
			edge_addend = in_reserve ? signed_cost : other;
		end else begin
			edge_addend = in_reserve ? other : signed_cost;
		end

		push_entry.last = last_item;
		if (command == ccd_pkg::CmdStart) begin
			push_entry.load   = 1'b1;
			push_entry.addend = removing_unit ? -fixed : fixed;
		end else begin
			push_entry.load   = 1'b0;
			push_entry.addend = edge_addend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removing_q  <= 1'b0;
			annealing_q <= 1'b0;
		end else if (push && command == ccd_pkg::CmdStart) begin
			removing_q  <= removing_unit;
			annealing_q <= from_annealing;
		end
	end

endmodule

/* rtl/core/ccd_queue.sv */
module ccd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccd_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            head_valid,
	output ccd_pkg::entry_t head,
	output logic            full
);

	ccd_pkg::entry_t                 entries_q [ccd_pkg::QueueDepth];
	logic [ccd_pkg::QueuePtrW-1:0]   wr_ptr_q;
	logic [ccd_pkg::QueuePtrW-1:0]   rd_ptr_q;
	logic [ccd_pkg::QueueCntW-1:0]   count_q;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == ccd_pkg::QueueCntW'(ccd_pkg::QueueDepth));
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ccd_pkg::QueueCntW'(ccd_pkg::QueueDepth))
		else $error("queue count beyond depth");

endmodule

/* rtl/core/ccd_back.sv */
module ccd_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ccd_pkg::CostW-1:0]       multiplier,
	input  logic                            head_valid,
	input  ccd_pkg::entry_t                 head,
	output logic                            pop,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [ccd_pkg::SumW-1:0] cost_delta,
	output logic                            saturated
);

	localparam int SumW   = ccd_pkg::SumW;
	localparam int ProdW  = 2 * ccd_pkg::CostW;
	localparam int HiW    = SumW - ccd_pkg::CostW + ccd_pkg::CostW;
	localparam int Shl    = ccd_pkg::CostW - FRAC_BITS;
	localparam logic [SumW-1:0] LimitPos = {1'b0, {(SumW-1){1'b1}}};
	localparam logic [SumW-1:0] LimitNeg = {1'b1, {(SumW-1){1'b0}}};

	logic signed [SumW-1:0] sum_q;
	logic                   clip_q;
	logic signed [SumW:0]   wide_sum;
	logic signed [SumW-1:0] next_sum;
	logic                   next_clip;

	logic valid_s1, valid_s2, valid_s3, valid_s4, result_valid_q;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_out;

	logic signed [SumW-1:0] sum_s1;
	logic                   clip_s1;
	logic [SumW-1:0]        mag_s2;
	logic                   neg_s2, clip_s2;
	logic [ProdW-1:0]       lo_s3;
	logic [HiW-1:0]         hi_s3;
	logic                   neg_s3, clip_s3;
	logic [SumW-1:0]        q_s4;
	logic                   neg_s4, clip_s4;
	logic signed [SumW-1:0] cost_delta_q;
	logic                   saturated_q;

	logic [ProdW-1:0] lo_prod;
	logic [HiW-1:0]   hi_prod;
	logic [SumW-1:0]  limit;
	logic [HiW-1:0]   hi_limit;
	logic             hi_over;
	logic [ProdW-1:0] q_sum;
	logic             q_over;

	assign ready_out = !result_valid_q || !result_stall;
	assign ready_s4  = !valid_s4 || ready_out;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;

	assign pop = head_valid && (!head.last || ready_s1);

	always_comb begin
		wide_sum = {sum_q[SumW-1], sum_q} +
		           (SumW+1)'(head.addend);
		if (head.load) begin
			next_sum  = SumW'(head.addend);
			next_clip = 1'b0;
		end else if (wide_sum[SumW] != wide_sum[SumW-1]) begin
			next_sum  = wide_sum[SumW] ? $signed(LimitNeg) : $signed(LimitPos);
			next_clip = 1'b1;
		end else begin
			next_sum  = wide_sum[SumW-1:0];
			next_clip = clip_q;
		end
	end

	always_comb begin
		lo_prod  = ProdW'(mag_s2[ccd_pkg::CostW-1:0]) * ProdW'(multiplier);
		hi_prod  = HiW'(mag_s2[SumW-1:ccd_pkg::CostW]) * HiW'(multiplier);
		limit    = neg_s3 ? LimitNeg : LimitPos;
		hi_limit = HiW'(limit >> Shl);
		hi_over  = hi_s3 > hi_limit;
		q_sum    = (ProdW'(hi_s3) << Shl) + (lo_s3 >> FRAC_BITS);
		q_over   = q_sum > ProdW'(limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			clip_q         <= 1'b0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				sum_q  <= next_sum;
				clip_q <= next_clip;
			end
			if (ready_s1)
				valid_s1 <= pop && head.last;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
			if (ready_s4)
				valid_s4 <= valid_s3;
			if (ready_out)
				result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pop && head.last) begin
			sum_s1  <= next_sum;
			clip_s1 <= next_clip;
		end
		if (ready_s2 && valid_s1) begin
			neg_s2  <= sum_s1[SumW-1];
			mag_s2  <= sum_s1[SumW-1] ? -sum_s1 : sum_s1;
			clip_s2 <= clip_s1;
		end
		if (ready_s3 && valid_s2) begin
			lo_s3   <= lo_prod;
			hi_s3   <= hi_prod;
			neg_s3  <= neg_s2;
			clip_s3 <= clip_s2;
		end
		if (ready_s4 && valid_s3) begin
			q_s4    <= (hi_over || q_over) ? limit : q_sum[SumW-1:0];
			neg_s4  <= neg_s3;
			clip_s4 <= clip_s3 || hi_over || q_over;
		end
		if (ready_out && valid_s4) begin
			cost_delta_q <= neg_s4 ? -$signed(q_s4) : $signed(q_s4);
			saturated_q  <= clip_s4;
		end
	end

	assign result_valid = result_valid_q;
	assign cost_delta   = cost_delta_q;
	assign saturated    = saturated_q;

	a_load_sets_sum: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.load |=> !clip_q &&
		sum_q == $past(SumW'(head.addend)))
		else $error("start transfer did not load the sum");

	a_last_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> valid_s1 && sum_s1 == sum_q)
		else $error("last transfer not captured for scaling");

	a_sign_carried: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2 && neg_s2 == $past(sum_s1[SumW-1]))
		else $error("sign lost between snapshot and magnitude");

endmodule

/* tb/tb_connection_cost_delta_unit.sv */
module tb_connection_cost_delta_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SumW     = ccd_pkg::SumW;
	localparam int CostW    = ccd_pkg::CostW;
	localparam int CfgIdxW  = ccd_pkg::CfgIdxW;
	localparam int CfgDataW = ccd_pkg::CfgDataW;
	localparam logic [CostW-1:0] MultiplierReset = ccd_pkg::MultiplierReset;
	localparam logic CmdStart = ccd_pkg::CmdStart;
	localparam logic CmdEdge  = ccd_pkg::CmdEdge;
	localparam logic [1:0] StAvailable = ccd_pkg::StAvailable;
	localparam logic [1:0] StReserve   = ccd_pkg::StReserve;
	localparam logic [1:0] StLockedIn  = ccd_pkg::StLockedIn;
	localparam logic [1:0] StLockedOut = ccd_pkg::StLockedOut;
	localparam logic [CfgIdxW-1:0] RegCostMultiplier = ccd_pkg::RegCostMultiplier;
	localparam logic [CfgIdxW-1:0] RegAsymmetricMode = ccd_pkg::RegAsymmetricMode;
	localparam logic [CfgIdxW-1:0] RegOptimiseInside = ccd_pkg::RegOptimiseInside;

	localparam int FracBits = 16;
	localparam int DrainCycles = 16;
	localparam int CycleLimit = 400000;
	localparam int PhaseItems = 90;
	localparam int DirRows = 17;
	localparam longint SumMax = 64'sh7FFF_FFFF_FFFF;
	localparam longint SumMin = -SumMax - 1;

	typedef struct {
		bit        cmd;
		bit [31:0] fixed;
		bit        rem;
		bit        ann;
		bit [1:0]  status;
		bit        origin;
		bit [31:0] ecost;
		bit        last;
	} unit_item_t;

	typedef struct {
		logic [SumW-1:0] delta;
		logic            sat;
	} cost_result_t;

	typedef struct {
		unit_item_t      it;
		bit              typed;
		logic [SumW-1:0] delta;
		logic            sat;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CfgIdxW-1:0]      cfg_index;
	logic [CfgDataW-1:0]     cfg_data;
	logic                    item_valid;
	logic                    item_stall;
	logic                    command;
	logic [CostW-1:0]        fixed_cost;
	logic                    removing_unit;
	logic                    from_annealing;
	logic [1:0]              neighbour_status;
	logic                    edge_from_unit;
	logic [CostW-1:0]        edge_cost;
	logic                    last_item;
	logic                    result_valid;
	logic                    result_stall;
	logic signed [SumW-1:0]  cost_delta;
	logic                    saturated;

	// predictor copy of block state and registers
	longint        pred_sum = 0;
	bit            pred_removing = 0;
	bit            pred_annealing = 0;
	bit            pred_clipped = 0;
	logic [31:0]   reg_mult = MultiplierReset;
	bit            reg_asym = 0;
	bit            reg_opt_in = 0;

	cost_result_t  pending_deltas [$];
	cost_result_t  got_want;
	int            errors = 0;
	int            cycles = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;

	// neighbour-before-start, start extremes, unused fields, remove w/o anneal,
	// continuation after a result
	dir_row_t dir_rows [DirRows] = '{
		'{'{CmdEdge, 32'h1234_5678, 1, 1, StAvailable, 0, 32'hFFFF_FFFF, 1}, 1,
			48'h0000_FFFF_FFFF, 1'b0},
		'{'{CmdStart, 32'hFFFF_FFFF, 0, 0, StLockedOut, 1, 32'hDEAD_BEEF, 1}, 1,
			48'h0000_FFFF_FFFF, 1'b0},
		'{'{CmdStart, 32'hFFFF_FFFF, 1, 1, StReserve, 1, 32'hFFFF_FFFF, 1}, 1,
			48'hFFFF_0000_0001, 1'b0},
		'{'{CmdEdge, 32'hFFFF_FFFF, 0, 0, StReserve, 1, 32'h0000_0001, 1}, 0, '0, 1'b0},
		'{'{CmdStart, 32'h0000_0000, 0, 0, StLockedIn, 0, 32'h8000_0000, 1}, 1,
			48'h0, 1'b0},
		'{'{CmdStart, 32'h0002_0000, 0, 1, StLockedIn, 1, 32'h5555_AAAA, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'hAAAA_5555, 1, 0, StAvailable, 1, 32'h0001_0000, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StReserve, 0, 32'h0000_8000, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StLockedIn, 1, 32'h0003_0000, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StLockedOut, 0, 32'hFFFF_FFFF, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StAvailable, 0, 32'h0000_0000, 1}, 0, '0, 1'b0},
		'{'{CmdStart, 32'h0005_0000, 1, 0, StAvailable, 0, 32'h0000_0000, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 1, StAvailable, 1, 32'h0001_8000, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StReserve, 0, 32'h0002_0000, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StLockedIn, 1, 32'h0000_0001, 0}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StLockedOut, 1, 32'h0004_0000, 1}, 0, '0, 1'b0},
		'{'{CmdEdge, 32'h0000_0000, 0, 0, StAvailable, 0, 32'h0000_4000, 1}, 0, '0, 1'b0}
	};

	connection_cost_delta_unit #(.FRAC_BITS(FracBits)) u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit predict_cost_change(input unit_item_t it, output cost_result_t res);
		longint      c;
		longint      sc;
		longint      other;
		longint      v;
		longint      t;
		bit          in_res;
		bit          neg;
		logic [63:0] mag;
		logic [95:0] prod;
		logic [95:0] q;
		logic [95:0] lim;
		if (it.cmd == CmdStart) begin
			pred_removing = it.rem;
			pred_annealing = it.ann;
			pred_clipped = 0;
			pred_sum = it.rem ? -longint'(it.fixed) : longint'(it.fixed);
		end else begin
			c = longint'(it.ecost);
			in_res = (it.status == StReserve) || (it.status == StLockedIn);
			v = 0;
			if (reg_asym) begin
				if (pred_annealing) begin
					if (it.origin) begin
						if (it.status == StAvailable)
							v = pred_removing ? -c : c;
					end else if (in_res) begin
						v = pred_removing ? c : -c;
					end
				end else if (it.status == StAvailable && it.origin) begin
					v = c;
				end
			end else begin
				sc = pred_removing ? -c : c;
				other = pred_annealing ? -sc : 0;
				if (reg_opt_in)
					v = in_res ? sc : other;
				else
					v = in_res ? other : sc;
			end
			t = pred_sum + v;
			if (t > SumMax) begin
				t = SumMax;
				pred_clipped = 1;
			end
			if (t < SumMin) begin
				t = SumMin;
				pred_clipped = 1;
			end
			pred_sum = t;
		end
		if (!it.last)
			return 0;
		neg = pred_sum < 0;
		mag = neg ? 64'(-pred_sum) : 64'(pred_sum);
		prod = {32'd0, mag} * {64'd0, reg_mult};
		q = prod >> FracBits;
		lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
		res.sat = pred_clipped;
		if (q > lim) begin
			q = lim;
			res.sat = 1'b1;
		end
		res.delta = neg ? -q[SumW-1:0] : q[SumW-1:0];
		return 1;
	endfunction

	task automatic report_mismatch(input string what, input logic [SumW-1:0] got,
			input logic [SumW-1:0] want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic send_item(input unit_item_t it, input bit typed,
			input logic [SumW-1:0] tdelta, input logic tsat);
		cost_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= it.cmd;
		fixed_cost <= it.fixed;
		removing_unit <= it.rem;
		from_annealing <= it.ann;
		neighbour_status <= it.status;
		edge_from_unit <= it.origin;
		edge_cost <= it.ecost;
		last_item <= it.last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (predict_cost_change(it, r)) begin
			if (typed) begin
				r.delta = tdelta;
				r.sat = tsat;
			end
			pending_deltas.push_back(r);
		end
	endtask

	task automatic settle_block();
		item_valid <= 1'b0;
		while (pending_deltas.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// leaves cfg_write high; the caller drops it after the last write
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			RegCostMultiplier: reg_mult = data;
			RegAsymmetricMode: reg_asym = data[0];
			RegOptimiseInside: reg_opt_in = data[0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_cost();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(32'h4_0000));
			default: return $urandom();
		endcase
	endfunction

	function automatic unit_item_t rand_item(input bit is_edge, input bit is_last);
		unit_item_t it;
		it.cmd = is_edge ? CmdEdge : CmdStart;
		it.fixed = rand_cost();
		it.rem = 1'($urandom_range(1));
		it.ann = 1'($urandom_range(1));
		it.status = 2'($urandom_range(3));
		it.origin = 1'($urandom_range(1));
		it.ecost = rand_cost();
		it.last = is_last;
		return it;
	endfunction

	task automatic run_units(input int target);
		int sent;
		int n_edges;
		int e;
		bit ends;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(49) == 0)
				settle_block();
			if ($urandom_range(9) == 0) begin
				send_item(rand_item(1'($urandom_range(1)), 1'($urandom_range(1))), 0, '0, 0);
				sent++;
			end else begin
				n_edges = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
				ends = $urandom_range(15) != 0;
				send_item(rand_item(0, ends && n_edges == 0), 0, '0, 0);
				sent++;
				for (e = 0; e < n_edges; e++) begin
					send_item(rand_item(1, ends && e == n_edges - 1), 0, '0, 0);
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_deltas.size() == 0) begin
				report_mismatch("unexpected result", cost_delta, '0);
			end else begin
				got_want = pending_deltas.pop_front();
				if (cost_delta !== got_want.delta)
					report_mismatch("cost_delta", cost_delta, got_want.delta);
				if (saturated !== got_want.sat)
					report_mismatch("saturated", SumW'(saturated), SumW'(got_want.sat));
			end
		end
	end

	always @(posedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] mults [8];
		int i;
		int k;
		mults = '{32'hFFFF_FFFF, 32'h0, 32'h0001_0000, $urandom(), 32'h8000_0000,
			32'h0000_0001, $urandom(), 32'h0001_8000};
		arst_n = 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_valid <= 1'b0;
		command <= CmdStart;
		fixed_cost <= '0;
		removing_unit <= 1'b0;
		from_annealing <= 1'b0;
		neighbour_status <= StAvailable;
		edge_from_unit <= 1'b0;
		edge_cost <= '0;
		last_item <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DirRows; i++)
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].delta, dir_rows[i].sat);
		settle_block();

		for (k = 0; k < 8; k++) begin
			write_reg(RegCostMultiplier, mults[k]);
			write_reg(RegAsymmetricMode, {31'($urandom()), k[1]});
			write_reg(RegOptimiseInside, {31'($urandom()), k[0]});
			cfg_write <= 1'b0;
			case (k % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 79; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 79; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			run_units(PhaseItems);
			settle_block();
		end

		stall_pct = 0;
		settle_block();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/core/ccd_pkg.sv
rtl/core/ccd_front.sv
rtl/core/ccd_queue.sv
rtl/core/ccd_back.sv
rtl/core/connection_cost_delta_unit.sv
tb/tb_connection_cost_delta_unit.sv
